### src/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// constants, charset codes and translation tables for the charset decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

  localparam int unsigned CodeW = 21;
  localparam int unsigned SetW  = 6;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [SetW-1:0]  set_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegLeftSet  = 2'd0,
    RegRightSet = 2'd1,
    RegSupPref  = 2'd2,
    RegNrcsMode = 2'd3
  } reg_idx_e;

  localparam set_t SetTurkishNrcs = 6'd19;
  localparam set_t SetAscii       = 6'd21;
  localparam set_t SetBritish     = 6'd22;
  localparam set_t SetDecGraph    = 6'd23;
  localparam set_t SetDecSup      = 6'd26;
  localparam set_t SetDecSupGraph = 6'd27;
  localparam set_t SetDecTech     = 6'd28;
  localparam set_t SetLatin1      = 6'd32;
  localparam set_t SetLatin5      = 6'd36;
  localparam int unsigned NatSets = 20;
  localparam logic [3:0] NoRow    = 4'hF;

  function automatic logic [15:0] graph_rom(input logic [4:0] a);
    logic [15:0] r;
    unique case (a)
      5'd0:  r = 16'h0020; 5'd1:  r = 16'h25C6; 5'd2:  r = 16'h2592; 5'd3:  r = 16'h2409;
      5'd4:  r = 16'h240C; 5'd5:  r = 16'h240D; 5'd6:  r = 16'h240A; 5'd7:  r = 16'h00B0;
      5'd8:  r = 16'h00B1; 5'd9:  r = 16'h2424; 5'd10: r = 16'h240B; 5'd11: r = 16'h2518;
      5'd12: r = 16'h2510; 5'd13: r = 16'h250C; 5'd14: r = 16'h2514; 5'd15: r = 16'h253C;
      5'd16: r = 16'h23BA; 5'd17: r = 16'h23BB; 5'd18: r = 16'h2500; 5'd19: r = 16'h23BC;
      5'd20: r = 16'h23BD; 5'd21: r = 16'h251C; 5'd22: r = 16'h2524; 5'd23: r = 16'h2534;
      5'd24: r = 16'h252C; 5'd25: r = 16'h2502; 5'd26: r = 16'h2264; 5'd27: r = 16'h2265;
      5'd28: r = 16'h03C0; 5'd29: r = 16'h2260; 5'd30: r = 16'h00A3; default: r = 16'h00B7;
    endcase
    return r;
  endfunction

  // indexed by the 7-bit code, valid for 0x21..0x7E
  function automatic logic [15:0] tech_rom(input logic [6:0] c);
    logic [15:0] r;
    unique case (c)
      7'h21: r = 16'h23B7; 7'h22: r = 16'h250C; 7'h23: r = 16'h2500; 7'h24: r = 16'h2320;
      7'h25: r = 16'h2321; 7'h26: r = 16'h2502; 7'h27: r = 16'h23A1; 7'h28: r = 16'h23A3;
      7'h29: r = 16'h23A4; 7'h2A: r = 16'h23A6; 7'h2B: r = 16'h239B; 7'h2C: r = 16'h239D;
      7'h2D: r = 16'h239E; 7'h2E: r = 16'h23A0; 7'h2F: r = 16'h23A8; 7'h30: r = 16'h23AC;
      7'h3C: r = 16'h2264; 7'h3D: r = 16'h2260; 7'h3E: r = 16'h2265; 7'h3F: r = 16'h222B;
      7'h40: r = 16'h2234; 7'h41: r = 16'h221D; 7'h42: r = 16'h221E; 7'h43: r = 16'h00F7;
      7'h44: r = 16'h0394; 7'h45: r = 16'h2207; 7'h46: r = 16'h03A6; 7'h47: r = 16'h0393;
      7'h48: r = 16'h223C; 7'h49: r = 16'h2243; 7'h4A: r = 16'h0398; 7'h4B: r = 16'h00D7;
      7'h4C: r = 16'h039B; 7'h4D: r = 16'h21D4; 7'h4E: r = 16'h21D2; 7'h4F: r = 16'h2261;
      7'h50: r = 16'h03A0; 7'h51: r = 16'h03A8; 7'h53: r = 16'h03A3;
      7'h56: r = 16'h221A; 7'h57: r = 16'h03A9; 7'h58: r = 16'h039E; 7'h59: r = 16'h03A5;
      7'h5A: r = 16'h2282; 7'h5B: r = 16'h2283; 7'h5C: r = 16'h2229; 7'h5D: r = 16'h222A;
      7'h5E: r = 16'h2227; 7'h5F: r = 16'h2228; 7'h60: r = 16'h00AC; 7'h61: r = 16'h03B1;
      7'h62: r = 16'h03B2; 7'h63: r = 16'h03C7; 7'h64: r = 16'h03B4; 7'h65: r = 16'h03B5;
      7'h66: r = 16'h03C6; 7'h67: r = 16'h03B3; 7'h68: r = 16'h03B7; 7'h69: r = 16'h03B9;
      7'h6A: r = 16'h03B8; 7'h6B: r = 16'h03BA; 7'h6C: r = 16'h03BB; 7'h6E: r = 16'h03BD;
      7'h6F: r = 16'h2202; 7'h70: r = 16'h03C0; 7'h71: r = 16'h03C8; 7'h72: r = 16'h03C1;
      7'h73: r = 16'h03C3; 7'h74: r = 16'h03C4; 7'h76: r = 16'h0192; 7'h77: r = 16'h03C9;
      7'h78: r = 16'h03BE; 7'h79: r = 16'h03C5; 7'h7A: r = 16'h03B6; 7'h7B: r = 16'h2190;
      7'h7C: r = 16'h2191; 7'h7D: r = 16'h2192; 7'h7E: r = 16'h2193;
      default: r = 16'hFFFE;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] nat_row(input set_t s);
    logic [3:0] r;
    unique case (s)
      6'd0, 6'd1:         r = 4'd0;
      6'd2, 6'd3:         r = 4'd1;
      6'd4:               r = 4'd2;
      6'd5, 6'd15:        r = 4'd3;
      6'd6, 6'd7:         r = 4'd4;
      6'd8:               r = 4'd5;
      6'd9:               r = 4'd6;
      6'd10:              r = 4'd7;
      6'd11:              r = 4'd8;
      6'd12, 6'd13, 6'd14: r = 4'd9;
      6'd16:              r = 4'd10;
      6'd19:              r = 4'd11;
      default:            r = NoRow;
    endcase
    return r;
  endfunction

  // row x position (0..11) -> replacement code
  function automatic logic [8:0] nat_rom(input logic [3:0] row, input logic [3:0] p);
    logic [8:0] t [12];
    logic [8:0] r;
    unique case (row)
      4'd0:  t = '{9'h23,9'h40,9'hC4,9'hD6,9'hC5,9'hDC,9'h5F,9'hE9,9'hE4,9'hF6,9'hE5,9'hFC};
      4'd1:  t = '{9'h23,9'hC9,9'hC6,9'hD8,9'hC5,9'hDC,9'h5F,9'hE9,9'hE6,9'hF8,9'hE5,9'hFC};
      4'd2:  t = '{9'h23,9'hA7,9'hC4,9'hD6,9'hDC,9'h5E,9'h5F,9'h60,9'hE4,9'hF6,9'hFC,9'hDF};
      4'd3:  t = '{9'h23,9'hE0,9'hE2,9'hE7,9'hEA,9'hEE,9'h5F,9'hF4,9'hE9,9'hF9,9'hE8,9'hFB};
      4'd4:  t = '{9'hA3,9'hE0,9'hB0,9'hE7,9'hA7,9'h5E,9'h5F,9'h60,9'hE9,9'hF9,9'hE8,9'hA8};
      4'd5:  t = '{9'hA3,9'hA7,9'hB0,9'hE7,9'hE9,9'h5E,9'h5F,9'hF9,9'hE0,9'hF2,9'hE8,9'hEC};
      4'd6:  t = '{9'hA3,9'hA7,9'hA1,9'hD1,9'hBF,9'h5E,9'h5F,9'h60,9'hB0,9'hF1,9'hE7,9'h7E};
      4'd7:  t = '{9'hA3,9'hBE,9'h133,9'hBD,9'h7C,9'h5E,9'h5F,9'h60,9'hA8,9'h66,9'hBC,9'hB4};
      4'd8:  t = '{9'hF9,9'hE0,9'hE9,9'hE7,9'hEA,9'hEE,9'hE8,9'hF4,9'hE4,9'hF6,9'hFC,9'hFB};
      4'd9:  t = '{9'h23,9'hC4,9'hC6,9'hD8,9'hC5,9'hDC,9'h5F,9'hE4,9'hE6,9'hF8,9'hE5,9'hFC};
      4'd10: t = '{9'h23,9'h40,9'hC3,9'hC7,9'hD5,9'h5E,9'h5F,9'h60,9'hE3,9'hE7,9'hF5,9'h7E};
      default:
        t = '{9'h23,9'h130,9'h15E,9'hD6,9'hC7,9'hDC,9'h5F,9'h11E,9'h15F,9'hF6,9'hE7,9'hFC};
    endcase
    if (p < 4'd12) begin
      r = t[p];
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/terminal_charset_decode.sv
// ----------------------------------------------------------------------------
// terminal_charset_decode
// translates received code points to unicode through dec style charsets
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  command   in         start_i, busy_o, code_in_i
//  result    out        done_o, code_out_o
//  config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i
//
//  one code point per cycle, result in the cycle after the transfer
//  the result is held in the single output register after the table lookup
//  busy_o stays low; the receiver cannot stall
//  reset restores the default charsets and clears done_o
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_charset_decode (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [tcd_pkg::CodeW-1:0]    code_in_i,
  output logic                              done_o,
  output logic [tcd_pkg::CodeW-1:0]         code_out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [tcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tcd_pkg::SetW-1:0]     cfg_wdata_i
);

  tcd_pkg::set_t left_q, right_q, sup_q;
  logic          nrcs_q;
  logic          done_q;
  tcd_pkg::code_t out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= tcd_pkg::SetAscii;
      right_q <= tcd_pkg::SetLatin1;
      sup_q <= tcd_pkg::SetDecSup;
      nrcs_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
      if (cfg_we_i) begin
        unique case (tcd_pkg::reg_idx_e'(cfg_idx_i))
          tcd_pkg::RegLeftSet:  left_q <= cfg_wdata_i;
          tcd_pkg::RegRightSet: right_q <= cfg_wdata_i;
          tcd_pkg::RegSupPref:  sup_q <= cfg_wdata_i;
          tcd_pkg::RegNrcsMode: nrcs_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      out_q <= out_d;
    end
  end

  tcd_pkg::set_t  set;
  logic [7:0]     c8, hi8;
  logic [6:0]     lo;
  logic [3:0]     row, pos;
  logic           hit;

  always_comb begin
    c8  = code_in_i[7:0];
    lo  = c8[6:0];
    hi8 = {1'b1, lo};
    set = c8[7] ? right_q : left_q;
    if (set == tcd_pkg::SetDecSup) set = sup_q;
    row = (set < 6'(tcd_pkg::NatSets)) ? tcd_pkg::nat_row(set) : tcd_pkg::NoRow;
    hit = 1'b1;
    pos = 4'd0;
    priority if (lo == 7'h23) begin
      pos = 4'd0;
    end else if (lo == 7'h40) begin
      pos = 4'd1;
    end else if (lo >= 7'h5B && lo <= 7'h60) begin
      pos = 4'(lo - 7'h59);
    end else if (lo >= 7'h7B && lo <= 7'h7E) begin
      pos = 4'(lo - 7'h73);
    end else begin
      hit = 1'b0;
    end
    out_d = tcd_pkg::CodeW'(c8);
    priority if (code_in_i > 21'hFF) begin
      out_d = code_in_i;
    end else if (c8 == 8'h7F) begin
      out_d = 21'h20;
    end else if (set == tcd_pkg::SetDecSup || set == tcd_pkg::SetDecSupGraph) begin
      unique case (hi8)
        8'hA8:   out_d = 21'hA4;
        8'hD7:   out_d = 21'h152;
        8'hDD:   out_d = 21'h178;
        8'hF7:   out_d = 21'h153;
        8'hFD:   out_d = 21'hFF;
        default: out_d = 21'(hi8);
      endcase
    end else if (set == tcd_pkg::SetDecGraph) begin
      out_d = (lo >= 7'h5F && lo <= 7'h7E) ?
              21'(tcd_pkg::graph_rom(5'(lo - 7'h5F))) : 21'(lo);
    end else if (set == tcd_pkg::SetLatin1 || set == tcd_pkg::SetBritish) begin
      if (nrcs_q) begin
        out_d = (lo == 7'h23) ? 21'hA3 : 21'(lo);
      end else begin
        out_d = 21'(hi8);
      end
    end else if (set == tcd_pkg::SetLatin5) begin
      unique case (hi8)
        8'hD0:   out_d = 21'h11E;
        8'hDD:   out_d = 21'h130;
        8'hDE:   out_d = 21'h15E;
        8'hF0:   out_d = 21'h11F;
        8'hFD:   out_d = 21'h131;
        8'hFE:   out_d = 21'h15F;
        default: out_d = 21'(hi8);
      endcase
    end else if (set == tcd_pkg::SetDecTech) begin
      out_d = (lo > 7'h20 && lo < 7'h7F) ? 21'(tcd_pkg::tech_rom(lo)) : 21'(lo);
    end else if (set == tcd_pkg::SetTurkishNrcs && lo == 7'h26) begin
      out_d = 21'h11F;
    end else if (row != tcd_pkg::NoRow) begin
      out_d = hit ? 21'(tcd_pkg::nat_rom(row, pos)) : 21'(lo);
    end
  end

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign code_out_o = out_q;

endmodule

`default_nettype wire

### dv/terminal_charset_decode_test.sv
// ----------------------------------------------------------------------------
// terminal_charset_decode_test
// drives code points through left charset codes 0..36 plus random settings and checks each decoded
// code point against a predictor built from the charset tables below
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module terminal_charset_decode_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  tcd_pkg::code_t code_in_i = '0;
  logic done_o;
  tcd_pkg::code_t code_out_o;
  logic cfg_we_i = 1'b0;
  logic [tcd_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  tcd_pkg::set_t cfg_wdata_i = '0;

  terminal_charset_decode u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("FAIL terminal_charset_decode");
    $finish;
  end

  tcd_pkg::set_t  m_left = tcd_pkg::SetAscii, m_right = tcd_pkg::SetLatin1;
  tcd_pkg::set_t  m_sup = tcd_pkg::SetDecSup;
  logic  m_nrcs = 1'b0;
  tcd_pkg::code_t decoded_q[$];
  int    err_cnt = 0;
  bit    quiet = 0;

  localparam logic [15:0] GraphTab [32] = '{
    16'h0020, 16'h25C6, 16'h2592, 16'h2409, 16'h240C, 16'h240D, 16'h240A, 16'h00B0,
    16'h00B1, 16'h2424, 16'h240B, 16'h2518, 16'h2510, 16'h250C, 16'h2514, 16'h253C,
    16'h23BA, 16'h23BB, 16'h2500, 16'h23BC, 16'h23BD, 16'h251C, 16'h2524, 16'h2534,
    16'h252C, 16'h2502, 16'h2264, 16'h2265, 16'h03C0, 16'h2260, 16'h00A3, 16'h00B7};

  localparam logic [15:0] TechTab [94] = '{
    16'h23B7, 16'h250C, 16'h2500, 16'h2320, 16'h2321, 16'h2502, 16'h23A1,
    16'h23A3, 16'h23A4, 16'h23A6, 16'h239B, 16'h239D, 16'h239E, 16'h23A0, 16'h23A8,
    16'h23AC, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE,
    16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'h2264, 16'h2260, 16'h2265, 16'h222B,
    16'h2234, 16'h221D, 16'h221E, 16'h00F7, 16'h0394, 16'h2207, 16'h03A6, 16'h0393,
    16'h223C, 16'h2243, 16'h0398, 16'h00D7, 16'h039B, 16'h21D4, 16'h21D2, 16'h2261,
    16'h03A0, 16'h03A8, 16'hFFFE, 16'h03A3, 16'hFFFE, 16'hFFFE, 16'h221A, 16'h03A9,
    16'h039E, 16'h03A5, 16'h2282, 16'h2283, 16'h2229, 16'h222A, 16'h2227, 16'h2228,
    16'h00AC, 16'h03B1, 16'h03B2, 16'h03C7, 16'h03B4, 16'h03B5, 16'h03C6, 16'h03B3,
    16'h03B7, 16'h03B9, 16'h03B8, 16'h03BA, 16'h03BB, 16'hFFFE, 16'h03BD, 16'h2202,
    16'h03C0, 16'h03C8, 16'h03C1, 16'h03C3, 16'h03C4, 16'hFFFE, 16'h0192, 16'h03C9,
    16'h03BE, 16'h03C5, 16'h03B6, 16'h2190, 16'h2191, 16'h2192, 16'h2193};

  localparam logic [8:0] NatTab [12][12] = '{
    '{9'h23,9'h40,9'hC4,9'hD6,9'hC5,9'hDC,9'h5F,9'hE9,9'hE4,9'hF6,9'hE5,9'hFC},
    '{9'h23,9'hC9,9'hC6,9'hD8,9'hC5,9'hDC,9'h5F,9'hE9,9'hE6,9'hF8,9'hE5,9'hFC},
    '{9'h23,9'hA7,9'hC4,9'hD6,9'hDC,9'h5E,9'h5F,9'h60,9'hE4,9'hF6,9'hFC,9'hDF},
    '{9'h23,9'hE0,9'hE2,9'hE7,9'hEA,9'hEE,9'h5F,9'hF4,9'hE9,9'hF9,9'hE8,9'hFB},
    '{9'hA3,9'hE0,9'hB0,9'hE7,9'hA7,9'h5E,9'h5F,9'h60,9'hE9,9'hF9,9'hE8,9'hA8},
    '{9'hA3,9'hA7,9'hB0,9'hE7,9'hE9,9'h5E,9'h5F,9'hF9,9'hE0,9'hF2,9'hE8,9'hEC},
    '{9'hA3,9'hA7,9'hA1,9'hD1,9'hBF,9'h5E,9'h5F,9'h60,9'hB0,9'hF1,9'hE7,9'h7E},
    '{9'hA3,9'hBE,9'h133,9'hBD,9'h7C,9'h5E,9'h5F,9'h60,9'hA8,9'h66,9'hBC,9'hB4},
    '{9'hF9,9'hE0,9'hE9,9'hE7,9'hEA,9'hEE,9'hE8,9'hF4,9'hE4,9'hF6,9'hFC,9'hFB},
    '{9'h23,9'hC4,9'hC6,9'hD8,9'hC5,9'hDC,9'h5F,9'hE4,9'hE6,9'hF8,9'hE5,9'hFC},
    '{9'h23,9'h40,9'hC3,9'hC7,9'hD5,9'h5E,9'h5F,9'h60,9'hE3,9'hE7,9'hF5,9'h7E},
    '{9'h23,9'h130,9'h15E,9'hD6,9'hC7,9'hDC,9'h5F,9'h11E,9'h15F,9'hF6,9'hE7,9'hFC}};

  localparam int NatRowOf [20] = '{0, 0, 1, 1, 2, 3, 4, 4, 5, 6, 7, 8, 9, 9, 9, 3, 10,
                                   -1, -1, 11};

  function automatic tcd_pkg::code_t decode_code(tcd_pkg::code_t c);
    tcd_pkg::set_t s;
    logic [6:0] lo;
    tcd_pkg::code_t hi;
    int row;
    if (c > 21'hFF) return c;
    if (c == 21'h7F) return 21'h20;
    s = (c > 21'h7F) ? m_right : m_left;
    if (s == tcd_pkg::SetDecSup) s = m_sup;
    lo = c[6:0];
    hi = c | 21'h80;
    if (s == tcd_pkg::SetDecSup || s == tcd_pkg::SetDecSupGraph) begin
      case (hi)
        21'hA8: return 21'hA4;
        21'hD7: return 21'h152;
        21'hDD: return 21'h178;
        21'hF7: return 21'h153;
        21'hFD: return 21'hFF;
        default: return hi;
      endcase
    end
    if (s == tcd_pkg::SetDecGraph) begin
      if (lo >= 7'h5F && lo <= 7'h7E) return tcd_pkg::code_t'(GraphTab[lo - 7'h5F]);
      return tcd_pkg::code_t'(lo);
    end
    if (s == tcd_pkg::SetLatin1 || s == tcd_pkg::SetBritish) begin
      if (m_nrcs) return (lo == 7'h23) ? 21'hA3 : tcd_pkg::code_t'(lo);
      return hi;
    end
    if (s == tcd_pkg::SetLatin5) begin
      case (hi)
        21'hD0: return 21'h11E;
        21'hDD: return 21'h130;
        21'hDE: return 21'h15E;
        21'hF0: return 21'h11F;
        21'hFD: return 21'h131;
        21'hFE: return 21'h15F;
        default: return hi;
      endcase
    end
    if (s == tcd_pkg::SetDecTech) begin
      if (lo > 7'h20 && lo < 7'h7F) return tcd_pkg::code_t'(TechTab[lo - 7'h21]);
      return tcd_pkg::code_t'(lo);
    end
    if (s == tcd_pkg::SetTurkishNrcs && lo == 7'h26) return 21'h11F;
    if (s < tcd_pkg::NatSets && NatRowOf[s] >= 0) begin
      row = NatRowOf[s];
      if (lo == 7'h23) return tcd_pkg::code_t'(NatTab[row][0]);
      if (lo == 7'h40) return tcd_pkg::code_t'(NatTab[row][1]);
      if (lo >= 7'h5B && lo <= 7'h60) return tcd_pkg::code_t'(NatTab[row][2 + lo - 7'h5B]);
      if (lo >= 7'h7B && lo <= 7'h7E) return tcd_pkg::code_t'(NatTab[row][8 + lo - 7'h7B]);
      return tcd_pkg::code_t'(lo);
    end
    return c;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    tcd_pkg::code_t exp_code;
    if (rst_ni && done_o) begin
      if (decoded_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %h", code_out_o);
      end else begin
        exp_code = decoded_q.pop_front();
        if (code_out_o !== exp_code) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("code_out mismatch: expected %h actual %h", exp_code, code_out_o);
        end
      end
    end
  end

  // start_i stays high after the transfer; callers drop it when they stop sending
  task automatic send_code(tcd_pkg::code_t c);
    while (!quiet && $urandom_range(99) < 31) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    code_in_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    decoded_q.push_back(decode_code(c));
  endtask

  task automatic write_reg(tcd_pkg::reg_idx_e idx, tcd_pkg::set_t val);
    start_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tcd_pkg::RegLeftSet:  m_left = val;
      tcd_pkg::RegRightSet: m_right = val;
      tcd_pkg::RegSupPref:  m_sup = val;
      default:              m_nrcs = val[0];
    endcase
  endtask

  function automatic tcd_pkg::code_t rand_code();
    int k;
    k = $urandom_range(9);
    if (k == 0) return tcd_pkg::code_t'($urandom_range(21'h10FFFF, 21'h100));
    if (k == 1) return tcd_pkg::code_t'($urandom);
    return tcd_pkg::code_t'($urandom_range(8'hFF));
  endfunction

  task automatic test_directed();
    tcd_pkg::code_t pts [$] = '{21'h0, 21'h7F, 21'h80, 21'hFF, 21'h100, 21'h10FFFF,
                                21'h1FFFFF};
    foreach (pts[i]) send_code(pts[i]);
    write_reg(tcd_pkg::RegLeftSet, tcd_pkg::SetTurkishNrcs);
    send_code(21'h26);
    send_code(21'h23);
    write_reg(tcd_pkg::RegRightSet, tcd_pkg::SetDecSup);
    write_reg(tcd_pkg::RegSupPref, tcd_pkg::SetDecSup);
    send_code(21'hA8);
    send_code(21'hD7);
    write_reg(tcd_pkg::RegNrcsMode, 6'd1);
    write_reg(tcd_pkg::RegLeftSet, tcd_pkg::SetBritish);
    send_code(21'h23);
    send_code(21'hA3);
    write_reg(tcd_pkg::RegLeftSet, tcd_pkg::SetDecTech);
    send_code(21'h31);
    send_code(21'hFF);
    write_reg(tcd_pkg::RegLeftSet, tcd_pkg::SetDecGraph);
    send_code(21'h5F);
    send_code(21'h7E);
    write_reg(tcd_pkg::RegLeftSet, 6'd63);
    send_code(21'h41);
    write_reg(tcd_pkg::RegRightSet, tcd_pkg::SetLatin5);
    send_code(21'hD0);
    send_code(21'hFE);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 38; ph++) begin
      write_reg(tcd_pkg::RegLeftSet,
                (ph < 37) ? tcd_pkg::set_t'(ph) : tcd_pkg::set_t'($urandom));
      write_reg(tcd_pkg::RegRightSet,
                tcd_pkg::set_t'($urandom_range(ph % 3 == 0 ? 63 : 36)));
      write_reg(tcd_pkg::RegSupPref,
                (ph % 4 == 0) ? tcd_pkg::SetDecSup : tcd_pkg::set_t'($urandom_range(36)));
      write_reg(tcd_pkg::RegNrcsMode, tcd_pkg::set_t'($urandom_range(1)));
      quiet = (ph >= 10 && ph < 14);
      repeat (25) send_code(rand_code());
    end
    quiet = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings();
    start_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS terminal_charset_decode");
    end else begin
      $display("FAIL terminal_charset_decode");
    end
    $finish;
  end

endmodule

### terminal_charset_decode.f
src/tcd_pkg.sv
src/terminal_charset_decode.sv
dv/terminal_charset_decode_test.sv
